// ===== hw/rtl/skvn_pkg.sv =====
// Package for the sorted key/value node: node size, field types, command and status codes,
// and the link record passed from cell to cell. No dependencies.
`default_nettype none
package skvn_pkg;

  localparam int ORDER   = 16;
  localparam int CNT_W   = $clog2(ORDER + 1);
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int ENTRY_W = 4;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0]        val_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_t;

  // What a cell hands to its upper neighbor every cycle
  typedef struct packed {
    logic valid;
    logic less;
    key_t key;
    val_t value;
  } cell_link_t;

endpackage
`default_nettype wire

// ===== hw/rtl/skvn_if.sv =====
// Handshake channels of the sorted key/value node: request and result.
// Depends on skvn_pkg.
`default_nettype none
interface skvn_req_if;
  logic             valid;
  logic             ready;
  skvn_pkg::cmd_t   command;
  skvn_pkg::key_t   search_key;
  skvn_pkg::val_t   entry_value;

  modport source (output valid, command, search_key, entry_value, input ready);
  modport sink   (input valid, command, search_key, entry_value, output ready);
endinterface

interface skvn_rsp_if;
  logic                          valid;
  logic                          ready;
  skvn_pkg::status_t             status;
  skvn_pkg::val_t                found_value;
  logic [skvn_pkg::ENTRY_W-1:0]  entry_count;
  logic                          has_room;

  modport source (output valid, status, found_value, entry_count, has_room, input ready);
  modport sink   (input valid, status, found_value, entry_count, has_room, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/skvn_cell.sv =====
// One slot of the sorted node: holds a key/value pair and a live bit, compares against
// the presented key and shifts in from its lower neighbor on insert. Depends on skvn_pkg.
`default_nettype none
module skvn_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   ins_en,
  input  skvn_pkg::key_t        key_in,
  input  skvn_pkg::val_t        value_in,
  input  skvn_pkg::cell_link_t  prev,
  output skvn_pkg::cell_link_t  link,
  output logic                  hit,
  output skvn_pkg::val_t        hit_value
);

  logic           valid_r, valid_nxt;
  skvn_pkg::key_t key_r, key_nxt;
  skvn_pkg::val_t value_r, value_nxt;
  logic           less;

  assign less      = valid_r && (key_r < key_in);
  assign hit       = valid_r && (key_r == key_in);
  assign hit_value = hit ? value_r : '0;

  assign link.valid = valid_r;
  assign link.less  = less;
  assign link.key   = key_r;
  assign link.value = value_r;

  // Slots below the insert point hold; the slot at it takes the new pair; above it shift up.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ins_en && !less) begin
      valid_nxt = valid_r || prev.less || prev.valid;
      if (prev.less) begin
        key_nxt   = key_in;
        value_nxt = value_in;
      end else begin
        key_nxt   = prev.key;
        value_nxt = prev.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_key_value_node_unit.sv =====
// Sorted key/value node built as a row of compare-and-shift cells.
// Latency: the result is registered and appears in the cycle after the request item is accepted.
// Throughput: one item per cycle while out_item is ready; all cells compare and shift in the same cycle.
// Reset clears the entry count, the cell live bits and the result valid; stored keys
// and values are left as they are and are never read until written.
`default_nettype none
module sorted_key_value_node_unit (
  input wire            clk,
  input wire            rst_n,
  skvn_req_if.sink      in_item,
  skvn_rsp_if.source    out_item
);

  localparam skvn_pkg::cnt_t FULL_CNT = skvn_pkg::CNT_W'(skvn_pkg::ORDER - 1);
  localparam skvn_pkg::cnt_t ROOM_MAX = skvn_pkg::CNT_W'(skvn_pkg::ORDER - 2);

  skvn_pkg::cell_link_t link [skvn_pkg::ORDER+1];
  logic [skvn_pkg::ORDER-1:0] hit;
  skvn_pkg::val_t hit_value [skvn_pkg::ORDER];

  skvn_pkg::cnt_t    count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  skvn_pkg::status_t status_r, status_nxt;
  skvn_pkg::val_t    found_r, found_nxt;
  logic [skvn_pkg::ENTRY_W-1:0] entry_r, entry_nxt;
  logic              room_r, room_nxt;

  logic           accept;
  logic           any_hit;
  logic           full;
  logic           ins_en;
  skvn_pkg::val_t found_any;

  assign in_item.ready = !out_valid_r || out_item.ready;
  assign accept        = in_item.valid && in_item.ready;

  // Below slot 0 sits a virtual entry smaller than every key
  assign link[0].valid = 1'b1;
  assign link[0].less  = 1'b1;
  assign link[0].key   = '0;
  assign link[0].value = '0;

  assign any_hit = |hit;
  assign full    = (count_r >= FULL_CNT);
  assign ins_en  = accept && (in_item.command == skvn_pkg::CMD_INSERT) && !any_hit && !full;

  for (genvar i = 0; i < skvn_pkg::ORDER; i++) begin : g_cell
    skvn_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ins_en    (ins_en),
      .key_in    (in_item.search_key),
      .value_in  (in_item.entry_value),
      .prev      (link[i]),
      .link      (link[i+1]),
      .hit       (hit[i]),
      .hit_value (hit_value[i])
    );
  end

  // Live keys are unique, so at most one cell drives a nonzero value
  always_comb begin
    found_any = '0;
    for (int i = 0; i < skvn_pkg::ORDER; i++) begin
      found_any = found_any | hit_value[i];
    end
  end

  always_comb begin
    count_nxt = ins_en ? count_r + skvn_pkg::CNT_W'(1) : count_r;
  end

  always_comb begin
    status_nxt = status_r;
    found_nxt  = found_r;
    entry_nxt  = entry_r;
    room_nxt   = room_r;
    if (accept) begin
      found_nxt = '0;
      if (in_item.command == skvn_pkg::CMD_INSERT) begin
        if (any_hit) begin
          status_nxt = skvn_pkg::ST_DUP;
        end else if (full) begin
          status_nxt = skvn_pkg::ST_FULL;
        end else begin
          status_nxt = skvn_pkg::ST_INSERTED;
        end
      end else begin
        if (any_hit) begin
          status_nxt = skvn_pkg::ST_HIT;
          found_nxt  = found_any;
        end else begin
          status_nxt = skvn_pkg::ST_MISS;
        end
      end
      entry_nxt = count_nxt[skvn_pkg::ENTRY_W-1:0];
      room_nxt  = (count_nxt <= ROOM_MAX);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    found_r  <= found_nxt;
    entry_r  <= entry_nxt;
    room_r   <= room_nxt;
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.status      = status_r;
  assign out_item.found_value = found_r;
  assign out_item.entry_count = entry_r;
  assign out_item.has_room    = room_r;

endmodule
`default_nettype wire
